// ----- design/eae_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eae_pkg
// Shared types, offsets and command encodings for the arithmetic element.
// ----------------------------------------------------------------------------
package eae_pkg;

  localparam logic [5:0] OffDiv   = 6'o00;
  localparam logic [5:0] OffAc    = 6'o02;
  localparam logic [5:0] OffAcHi  = 6'o03;
  localparam logic [5:0] OffMq    = 6'o04;
  localparam logic [5:0] OffMqHi  = 6'o05;
  localparam logic [5:0] OffMul   = 6'o06;
  localparam logic [5:0] OffScSr  = 6'o10;
  localparam logic [5:0] OffSr    = 6'o11;
  localparam logic [5:0] OffNorm  = 6'o12;
  localparam logic [5:0] OffLsh   = 6'o14;
  localparam logic [5:0] OffAsh   = 6'o16;

  typedef struct packed {
    logic        op;
    logic [5:0]  offset;
    logic        byte_write;
    logic [15:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        nxm;
  } out_word_t;

  typedef enum logic [2:0] {
    OpNone  = 3'd0,
    OpDiv   = 3'd1,
    OpMul   = 3'd2,
    OpNorm  = 3'd3,
    OpShift = 3'd4
  } long_op_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_long;
    logic done;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- design/eae_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eae_ctrl
// Controller that sequences one word through the datapath.
// ----------------------------------------------------------------------------
module eae_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire eae_pkg::dp_status_t status,
  output eae_pkg::dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      StIdle: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = StRun;
        end
      end
      StRun: begin
        if (!status.is_long || status.done) begin
          state_next = StDone;
        end else begin
          cmd.step = 1'b1;
        end
      end
      StDone: begin
        cmd.finish = 1'b1;
        state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

  assign busy = (state != StIdle);

endmodule
`default_nettype wire

// ----- design/eae_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eae_dp
// Registers and iterative shift-add/subtract datapath.
// ----------------------------------------------------------------------------
module eae_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire eae_pkg::in_word_t in_word,
  input  wire eae_pkg::dp_cmd_t  cmd,
  output eae_pkg::dp_status_t    status,
  output eae_pkg::out_word_t     out_word,
  output logic                   out_valid
);

  logic [15:0] ac, mq;
  logic [5:0]  sc;
  logic [7:0]  sr;
  eae_pkg::in_word_t req;
  eae_pkg::long_op_t lop;
  logic [5:0]  cnt;
  logic [31:0] x;
  logic [31:0] mag;
  logic [16:0] dvs;
  logic [15:0] rem;
  logic        dneg, qneg, zdiv, carry;
  logic [31:0] pacc;
  logic [15:0] mcand;

  logic [5:0]  n;
  logic        rshift;
  logic [5:0]  rn;
  logic [16:0] trial;
  logic [1:0]  top;
  logic        norm_stop;
  logic [7:0]  flags;
  logic [31:0] q32, quo;
  logic [15:0] rfin;
  logic        qovf;
  eae_pkg::out_word_t out_word_next;

  function automatic logic [7:0] refresh(input logic [7:0] s, input logic [15:0] a,
                                         input logic [15:0] m);
    logic [7:0] r;
    r    = s & 8'o301;
    r[1] = (!m[15] && a == 16'h0000) || (m[15] && a == 16'hFFFF);
    r[2] = (a == 16'h0000) && (m == 16'h0000);
    r[3] = (m == 16'h0000);
    r[4] = (a == 16'h0000);
    r[5] = (a == 16'hFFFF);
    return r;
  endfunction

  assign n      = req.write_data[5:0];
  assign rshift = n[5];
  assign rn     = 6'd0 - n;
  assign trial  = {rem, mag[31]} - dvs;
  assign top    = x[31:30];
  assign norm_stop = (x == 32'hC000_0000) || (top == 2'b01) || (top == 2'b10) ||
                     (cnt == 6'd31);
  assign q32    = mag;
  assign quo    = qneg ? (32'd0 - q32) : q32;
  assign rfin   = dneg ? (16'd0 - rem) : rem;
  assign qovf   = qneg ? (q32 > 32'd32768) : (q32 > 32'd32767);
  assign flags  = refresh(sr, ac, mq);

  always_comb begin
    status.is_long = (lop != eae_pkg::OpNone);
    case (lop)
      eae_pkg::OpDiv:   status.done = zdiv || (cnt == 6'd32);
      eae_pkg::OpMul:   status.done = (cnt == 6'd16);
      eae_pkg::OpNorm:  status.done = norm_stop;
      eae_pkg::OpShift: status.done = rshift ? (cnt == rn) : (cnt == n);
      default:          status.done = 1'b1;
    endcase
  end

  always_comb begin
    out_word_next = '0;
    if (!req.op) begin
      case (req.offset)
        eae_pkg::OffAc:   out_word_next.read_data = ac;
        eae_pkg::OffMq:   out_word_next.read_data = mq;
        eae_pkg::OffNorm: out_word_next.read_data = {10'd0, sc};
        eae_pkg::OffScSr: out_word_next.read_data = {flags, 2'b00, sc};
        eae_pkg::OffSr:   out_word_next.read_data = {flags, 8'd0};
        eae_pkg::OffDiv, eae_pkg::OffMul, eae_pkg::OffLsh, eae_pkg::OffAsh: ;
        default: out_word_next.nxm = 1'b1;
      endcase
    end else begin
      case (req.offset)
        eae_pkg::OffDiv, eae_pkg::OffAc, eae_pkg::OffAcHi, eae_pkg::OffMq,
        eae_pkg::OffMqHi, eae_pkg::OffMul, eae_pkg::OffScSr, eae_pkg::OffSr,
        eae_pkg::OffNorm, eae_pkg::OffLsh, eae_pkg::OffAsh: ;
        default: out_word_next.nxm = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ac <= '0;
      mq <= '0;
      sc <= '0;
      sr <= '0;
      lop <= eae_pkg::OpNone;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.load) begin
        req   <= in_word;
        cnt   <= '0;
        carry <= 1'b0;
        x     <= {ac, mq};
        if (in_word.op) begin
          case (in_word.offset)
            eae_pkg::OffDiv: begin
              lop  <= eae_pkg::OpDiv;
              dneg <= ac[15];
              qneg <= ac[15] ^ in_word.write_data[15];
              zdiv <= (in_word.write_data == 16'd0);
              mag  <= ac[15] ? (32'd0 - {ac, mq}) : {ac, mq};
              dvs  <= in_word.write_data[15] ? (17'd0 - {1'b1, in_word.write_data})
                                              : {1'b0, in_word.write_data};
              rem  <= '0;
            end
            eae_pkg::OffMul: begin
              lop   <= eae_pkg::OpMul;
              pacc  <= '0;
              mcand <= in_word.write_data;
            end
            eae_pkg::OffNorm:  lop <= eae_pkg::OpNorm;
            eae_pkg::OffLsh, eae_pkg::OffAsh: lop <= eae_pkg::OpShift;
            default: lop <= eae_pkg::OpNone;
          endcase
        end else begin
          lop <= eae_pkg::OpNone;
        end
      end
      if (cmd.step) begin
        cnt <= cnt + 6'd1;
        case (lop)
          eae_pkg::OpDiv: begin
            if (!trial[16]) begin
              rem <= trial[15:0];
              mag <= {mag[30:0], 1'b1};
            end else begin
              rem <= {rem[14:0], mag[31]};
              mag <= {mag[30:0], 1'b0};
            end
          end
          eae_pkg::OpMul: begin
            if (cnt == 6'd15) begin
              pacc <= (mcand[15] ? pacc - ({{16{mq[15]}}, mq} << 15)
                                 : pacc) ;
            end else if (mcand[cnt[3:0]]) begin
              pacc <= pacc + ({{16{mq[15]}}, mq} << cnt[3:0]);
            end
          end
          eae_pkg::OpNorm: x <= {x[30:0], 1'b0};
          eae_pkg::OpShift: begin
            if (rshift) begin
              carry <= x[0];
              x     <= {(req.offset == eae_pkg::OffAsh) & x[31], x[31:1]};
            end else begin
              carry <= x[31];
              x     <= {x[30:0], 1'b0};
            end
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        out_word <= out_word_next;
        lop      <= eae_pkg::OpNone;
        if (!req.op) begin
          if (req.offset inside {eae_pkg::OffScSr, eae_pkg::OffSr}) begin
            sr <= flags;
          end
        end else begin
          case (req.offset)
            eae_pkg::OffDiv: begin
              sc <= '0;
              if (zdiv) begin
                sr <= (sr & 8'o076) | (dneg ? 8'o100 : 8'o200);
              end else begin
                mq <= quo[15:0];
                ac <= rfin;
                if (qovf) sr <= (sr & 8'o076) | (dneg ? 8'o100 : 8'o200);
                else if (qneg && q32 != 32'd0) sr <= (sr & 8'o076) | 8'o300;
                else sr <= sr & 8'o076;
              end
            end
            eae_pkg::OffAc: ac <= req.byte_write ?
                {{8{req.write_data[7]}}, req.write_data[7:0]} : req.write_data;
            eae_pkg::OffAcHi: ac <= {req.write_data[7:0], ac[7:0]};
            eae_pkg::OffMq: begin
              mq <= req.byte_write ?
                  {{8{req.write_data[7]}}, req.write_data[7:0]} : req.write_data;
              ac <= {16{req.byte_write ? req.write_data[7] : req.write_data[15]}};
            end
            eae_pkg::OffMqHi: begin
              mq <= {req.write_data[7:0], mq[7:0]};
              ac <= {16{req.write_data[7]}};
            end
            eae_pkg::OffMul: begin
              sc <= '0;
              ac <= pacc[31:16];
              mq <= pacc[15:0];
              sr <= (sr & 8'o076) | (pacc[31] ? 8'o300 : 8'o000);
            end
            eae_pkg::OffScSr: begin
              if (!req.byte_write) begin
                sr <= req.write_data[15:8];
                sc <= req.write_data[5:0];
              end
            end
            eae_pkg::OffSr: ;
            eae_pkg::OffNorm: begin
              sc <= cnt;
              ac <= x[31:16];
              mq <= x[15:0];
            end
            eae_pkg::OffLsh, eae_pkg::OffAsh: begin
              ac <= x[31:16];
              mq <= x[15:0];
              sr <= refresh({(ac[15] ^ x[31]), sr[6:1], carry}, x[31:16], x[15:0]);
            end
            default: ;
          endcase
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/extended_arithmetic_element_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// extended_arithmetic_element_top
// Bus-register arithmetic unit: AC, MQ, step count and status.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; one result word follows
// on result with done high for one cycle, and the receiver cannot stall it.
// Register reads and loads run no datapath steps. Divide runs one restoring step
// per cycle over 32 quotient bits, except a divide by zero, which skips the steps.
// Multiply runs one shift-add step per multiplier bit, normalize and shifts
// one step per bit position moved.
// ----------------------------------------------------------------------------
module extended_arithmetic_element_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire eae_pkg::in_word_t  in_word,
  output logic                    done,
  output eae_pkg::out_word_t      result
);

  eae_pkg::dp_cmd_t    cmd;
  eae_pkg::dp_status_t status;

  eae_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  eae_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_word  (result),
    .out_valid (done)
  );

endmodule
`default_nettype wire

// ----- tb/extended_arithmetic_element_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_arithmetic_element_top_tb
// Self-checking bench for the arithmetic element: directed register accesses
// and operations, then random access sequences under varying idle patterns,
// each result word compared against a cycle-free model of AC, MQ, SC and SR.
// ----------------------------------------------------------------------------
module extended_arithmetic_element_top_tb;

  localparam int WatchdogLimit = 2000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  eae_pkg::in_word_t  in_word;
  logic               done;
  eae_pkg::out_word_t result;

  extended_arithmetic_element_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_word(in_word), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [15:0] ac, mq;
  logic [5:0]  sc;
  logic [7:0]  sr;
  eae_pkg::out_word_t pending_words[$];
  int          errors;
  int          words_sent;
  int          words_checked;
  int          idle_pct;
  int          quiet_cycles;

  function automatic void refresh_status();
    logic [7:0] s;
    s = sr & 8'o301;
    if ((!mq[15] && ac == 16'h0000) || (mq[15] && ac == 16'hFFFF)) s |= 8'o002;
    if (ac == 0 && mq == 0) s |= 8'o004;
    if (mq == 0) s |= 8'o010;
    if (ac == 0) s |= 8'o020;
    if (ac == 16'hFFFF) s |= 8'o040;
    sr = s;
  endfunction

  function automatic logic [15:0] load_value(logic [15:0] d, logic b);
    return b ? {{8{d[7]}}, d[7:0]} : d;
  endfunction

  function automatic void divide_acmq(logic [15:0] d);
    longint dividend, divisor, q, r;
    dividend = longint'($signed({ac, mq}));
    divisor = longint'($signed(d));
    sc = 0;
    sr &= 8'o076;
    if (divisor == 0) begin
      sr |= (dividend < 0) ? 8'o100 : 8'o200;
      return;
    end
    q = dividend / divisor;
    r = dividend % divisor;
    mq = q[15:0];
    ac = r[15:0];
    if (q > 32767 || q < -32768) sr |= (dividend < 0) ? 8'o100 : 8'o200;
    else if (q < 0) sr |= 8'o300;
  endfunction

  function automatic void shift_acmq(logic [15:0] d, logic arith);
    logic [31:0] x;
    logic        old_sign;
    int          n;
    x = {ac, mq};
    old_sign = x[31];
    n = d[5:0];
    sr &= 8'o176;
    if (n > 31) begin
      n = 64 - n;
      sr[0] = x[n-1];
      x = (arith && old_sign) ? ~((~x) >> n) : x >> n;
    end else if (n > 0) begin
      sr[0] = x[32-n];
      x = x << n;
    end
    if (old_sign != x[31]) sr[7] = 1'b1;
    {ac, mq} = x;
    refresh_status();
  endfunction

  function automatic eae_pkg::out_word_t predict_access(eae_pkg::in_word_t w);
    eae_pkg::out_word_t o;
    logic [31:0]        x;
    longint             p;
    int                 n;
    o = '0;
    if (!w.op) begin
      case (w.offset)
        eae_pkg::OffAc:   o.read_data = ac;
        eae_pkg::OffMq:   o.read_data = mq;
        eae_pkg::OffNorm: o.read_data = {10'd0, sc};
        eae_pkg::OffScSr: begin refresh_status(); o.read_data = {sr, 2'b00, sc}; end
        eae_pkg::OffSr:   begin refresh_status(); o.read_data = {sr, 8'h00}; end
        eae_pkg::OffDiv, eae_pkg::OffMul, eae_pkg::OffLsh, eae_pkg::OffAsh:
          o.read_data = 16'h0000;
        default: o.nxm = 1'b1;
      endcase
    end else begin
      case (w.offset)
        eae_pkg::OffDiv:  divide_acmq(w.write_data);
        eae_pkg::OffAc:   ac = load_value(w.write_data, w.byte_write);
        eae_pkg::OffAcHi: ac = {w.write_data[7:0], ac[7:0]};
        eae_pkg::OffMq: begin
          mq = load_value(w.write_data, w.byte_write);
          ac = {16{mq[15]}};
        end
        eae_pkg::OffMqHi: begin
          mq = {w.write_data[7:0], mq[7:0]};
          ac = {16{mq[15]}};
        end
        eae_pkg::OffMul: begin
          p = longint'($signed(mq)) * longint'($signed(w.write_data));
          sc = 0;
          {ac, mq} = p[31:0];
          sr &= 8'o076;
          if (ac[15]) sr |= 8'o300;
        end
        eae_pkg::OffScSr: if (!w.byte_write) begin
          sr = w.write_data[15:8];
          sc = w.write_data[5:0];
        end
        eae_pkg::OffSr: ;
        eae_pkg::OffNorm: begin
          x = {ac, mq};
          for (n = 0; n < 31; n++) begin
            if (x == 32'hC000_0000 || x[31] != x[30]) break;
            x = x << 1;
          end
          sc = n[5:0];
          {ac, mq} = x;
        end
        eae_pkg::OffLsh: shift_acmq(w.write_data, 1'b0);
        eae_pkg::OffAsh: shift_acmq(w.write_data, 1'b1);
        default: o.nxm = 1'b1;
      endcase
    end
    return o;
  endfunction

  task automatic send_word(logic op, logic [5:0] off, logic b, logic [15:0] d);
    eae_pkg::in_word_t w;
    w = '{op: op, offset: off, byte_write: b, write_data: d};
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    pending_words.push_back(predict_access(w));
    words_sent++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word read_data=%h nxm=%b", $time,
                   result.read_data, result.nxm);
          errors++;
        end else begin
          eae_pkg::out_word_t exp_w;
          exp_w = pending_words.pop_front();
          words_checked++;
          if (exp_w.read_data !== result.read_data)
          begin
            $display("%0t: read_data expected %h actual %h", $time,
                     exp_w.read_data, result.read_data);
            errors++;
          end
          if (exp_w.nxm !== result.nxm) begin
            $display("%0t: nxm expected %b actual %b", $time, exp_w.nxm, result.nxm);
            errors++;
          end
        end
      end
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("extended_arithmetic_element_top regression: fail");
        $finish;
      end
    end
  end

  task automatic test_register_loads();
    send_word(1'b1, eae_pkg::OffAc, 1'b0, 16'hFFFF);
    send_word(1'b0, eae_pkg::OffAc, 1'b0, 16'h0000);
    send_word(1'b1, eae_pkg::OffAc, 1'b1, 16'h0080);
    send_word(1'b0, eae_pkg::OffAc, 1'b0, 16'h0000);
    send_word(1'b1, eae_pkg::OffAcHi, 1'b1, 16'h5A12);
    send_word(1'b0, eae_pkg::OffAc, 1'b0, 16'h0000);
    send_word(1'b1, eae_pkg::OffMq, 1'b1, 16'h007F);
    send_word(1'b1, eae_pkg::OffMqHi, 1'b0, 16'h0080);
    send_word(1'b0, eae_pkg::OffMq, 1'b0, 16'h0000);
    send_word(1'b0, eae_pkg::OffScSr, 1'b0, 16'h0000);
    send_word(1'b1, eae_pkg::OffScSr, 1'b0, 16'hFFFF);
    send_word(1'b1, eae_pkg::OffScSr, 1'b1, 16'h0000);
    send_word(1'b1, eae_pkg::OffSr, 1'b0, 16'h1234);
    send_word(1'b0, eae_pkg::OffSr, 1'b0, 16'h0000);
    send_word(1'b0, eae_pkg::OffNorm, 1'b0, 16'h0000);
    send_word(1'b0, eae_pkg::OffDiv, 1'b0, 16'h0000);
    send_word(1'b0, 6'o77, 1'b0, 16'h0000);
    send_word(1'b1, 6'o01, 1'b1, 16'hFFFF);
  endtask

  task automatic test_operations();
    send_word(1'b1, eae_pkg::OffMq, 1'b0, 16'h8000);
    send_word(1'b1, eae_pkg::OffMul, 1'b0, 16'h8000);
    send_word(1'b0, eae_pkg::OffScSr, 1'b0, 16'h0000);
    send_word(1'b1, eae_pkg::OffDiv, 1'b0, 16'h0000);
    send_word(1'b1, eae_pkg::OffDiv, 1'b0, 16'hFFFF);
    send_word(1'b1, eae_pkg::OffMq, 1'b0, 16'hFFF9);
    send_word(1'b1, eae_pkg::OffDiv, 1'b0, 16'h0002);
    send_word(1'b0, eae_pkg::OffScSr, 1'b0, 16'h0000);
    send_word(1'b1, eae_pkg::OffMq, 1'b0, 16'h0001);
    send_word(1'b1, eae_pkg::OffNorm, 1'b0, 16'h0000);
    send_word(1'b1, eae_pkg::OffLsh, 1'b0, 16'h0000);
    send_word(1'b1, eae_pkg::OffAsh, 1'b0, 16'h0020);
    send_word(1'b1, eae_pkg::OffLsh, 1'b0, 16'h003F);
    send_word(1'b1, eae_pkg::OffLsh, 1'b0, 16'h001F);
    send_word(1'b0, eae_pkg::OffSr, 1'b0, 16'h0000);
    send_word(1'b1, eae_pkg::OffMq, 1'b0, 16'h0000);
    send_word(1'b1, eae_pkg::OffNorm, 1'b0, 16'h0000);
    send_word(1'b0, eae_pkg::OffScSr, 1'b0, 16'h0000);
  endtask

  task automatic random_access();
    logic [5:0] off;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 8) off = 6'($urandom_range(63));
    else begin
      case ($urandom_range(11))
        0: off = eae_pkg::OffDiv;
        1: off = eae_pkg::OffAc;
        2: off = eae_pkg::OffAcHi;
        3: off = eae_pkg::OffMq;
        4: off = eae_pkg::OffMqHi;
        5: off = eae_pkg::OffMul;
        6: off = eae_pkg::OffScSr;
        7: off = eae_pkg::OffSr;
        8: off = eae_pkg::OffNorm;
        9: off = eae_pkg::OffLsh;
        10: off = eae_pkg::OffAsh;
        default: off = eae_pkg::OffAc;
      endcase
    end
    send_word($urandom_range(99) < 65, off, 1'($urandom_range(1)),
              16'($urandom_range(16'hFFFF)));
  endtask

  task automatic test_random_phase(int pct, int count);
    idle_pct = pct;
    repeat (count) random_access();
    idle_pct = 0;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    in_word = '0;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_register_loads();
    test_operations();
    test_random_phase(0, 160);
    drain_results();
    test_random_phase(51, 160);
    test_random_phase(0, 150);
    test_random_phase(33, 150);
    drain_results();
    $display("Covered %0d words over all offsets, loads, divide, multiply,", words_sent);
    $display("normalize and shifts with %0d result words checked.", words_checked);
    if (errors == 0) begin
      $display("extended_arithmetic_element_top regression: pass");
    end else begin
      $display("extended_arithmetic_element_top regression: fail");
    end
    $finish;
  end
endmodule
